FILE: hw/rtl/bpc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the button press classifier.
// No dependencies; imported by every module of the block.
package bpc_pkg;

  localparam int BPC_COUNT_BITS = 16;
  localparam int TIMER_BITS     = 16;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_PRESS_MODE  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE_TICKS   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_PRESS_TICKS = 2'd2;

  // Reset values of the registers
  localparam logic                  RST_LONG_PRESS_MODE  = 1'b0;
  localparam logic [TIMER_BITS-1:0] RST_DEBOUNCE_TICKS   = 16'd50;
  localparam logic [TIMER_BITS-1:0] RST_LONG_PRESS_TICKS = 16'd1000;

  // Press event codes
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_SHORT = 2'd1;
  localparam logic [1:0] EV_LONG  = 2'd2;

  typedef struct packed {
    logic                  long_press_mode;
    logic [TIMER_BITS-1:0] debounce_ticks;
    logic [TIMER_BITS-1:0] long_press_ticks;
  } bpc_cfg_t;

endpackage

FILE: hw/rtl/bpc_core.sv
`timescale 1ns / 1ps
// Edge detection, debounce timer, held counter and press classification.
// Depends on bpc_pkg; state advances once per accepted item.
module bpc_core import bpc_pkg::*; #(
  parameter int COUNT_BITS = BPC_COUNT_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       pin_level,
  input  bpc_cfg_t   cfg,
  output logic [1:0] press_event
);

  localparam int CMP_W = (COUNT_BITS > TIMER_BITS) ? COUNT_BITS : TIMER_BITS;

  logic                  last_level, last_level_next;
  logic                  timer_pending, timer_pending_next;
  logic [TIMER_BITS-1:0] timer_remaining, timer_remaining_next;
  logic [COUNT_BITS-1:0] held_count, held_count_next;

  logic [COUNT_BITS-1:0] held_inc;
  logic                  expire;
  logic                  pending_after;
  logic [TIMER_BITS-1:0] remaining_after;
  logic                  fall;
  logic                  rise;
  logic                  arm;

  always_comb begin
    // saturating held count, updated before the expiry check
    held_inc = (held_count == '1) ? held_count : held_count + COUNT_BITS'(1);

    expire          = timer_pending && (timer_remaining <= TIMER_BITS'(1));
    pending_after   = timer_pending && !expire;
    remaining_after = (timer_pending && timer_remaining != '0) ?
                      timer_remaining - TIMER_BITS'(1) : timer_remaining;

    if (!expire) begin
      press_event = EV_NONE;
    end else if (cfg.long_press_mode &&
                 (CMP_W'(held_inc) >= CMP_W'(cfg.long_press_ticks))) begin
      press_event = EV_LONG;
    end else begin
      press_event = EV_SHORT;
    end

    fall = last_level && !pin_level;
    rise = !last_level && pin_level;
    arm  = (fall && !cfg.long_press_mode) || (rise && cfg.long_press_mode);

    timer_pending_next   = pending_after;
    timer_remaining_next = remaining_after;
    // a pending timer ignores the arming edge
    if (arm && !pending_after) begin
      timer_pending_next   = 1'b1;
      timer_remaining_next = (cfg.debounce_ticks == '0) ? TIMER_BITS'(1) : cfg.debounce_ticks;
    end

    held_count_next = fall ? '0 : held_inc;
    last_level_next = pin_level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level      <= 1'b1;
      timer_pending   <= 1'b0;
      timer_remaining <= '0;
      held_count      <= '1;
    end else if (step) begin
      last_level      <= last_level_next;
      timer_pending   <= timer_pending_next;
      timer_remaining <= timer_remaining_next;
      held_count      <= held_count_next;
    end
  end

endmodule

FILE: hw/rtl/button_press_classifier_unit.sv
`timescale 1ns / 1ps
// Top level of the button press classifier: config registers, core, result register.
// Depends on bpc_pkg and bpc_core.
//
//   channel   signals                                direction   payload
//   in        in_valid, in_stall, pin_level           sink        pin_level
//   out       out_valid, out_stall, press_event       source      press_event
//   cfg       cfg_valid, cfg_ready, cfg_index/data    sink        register write
//
// One item is accepted per cycle while the input is not stalled; its result appears in
// the result register on the next cycle, from the counter and compare path of the core.
// Reset (rst, synchronous) restores the config defaults and the released state.
// The input stalls only while a result is held by a stalled output.
// Configuration writes are taken every cycle.
module button_press_classifier_unit import bpc_pkg::*; #(
  parameter int COUNT_BITS = BPC_COUNT_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     pin_level,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               press_event,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  bpc_cfg_t   cfg;
  logic       step;
  logic [1:0] core_event;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign step      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_mode  <= RST_LONG_PRESS_MODE;
      cfg.debounce_ticks   <= RST_DEBOUNCE_TICKS;
      cfg.long_press_ticks <= RST_LONG_PRESS_TICKS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LONG_PRESS_MODE:  cfg.long_press_mode  <= cfg_data[0];
        CFG_DEBOUNCE_TICKS:   cfg.debounce_ticks   <= cfg_data[TIMER_BITS-1:0];
        CFG_LONG_PRESS_TICKS: cfg.long_press_ticks <= cfg_data[TIMER_BITS-1:0];
        default: ;
      endcase
    end
  end

  bpc_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .pin_level  (pin_level),
    .cfg        (cfg),
    .press_event(core_event)
  );

  // result register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      press_event <= core_event;
    end
  end

endmodule

FILE: hw/rtl/bpc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the button press classifier, bound to the top level.
// Depends on bpc_pkg and button_press_classifier_unit.
module bpc_checker import bpc_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] press_event
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(press_event))
    else $error("stalled result changed or vanished");

  a_event_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (press_event == EV_NONE || press_event == EV_SHORT ||
                   press_event == EV_LONG))
    else $error("press_event carries an undefined code");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item produced no result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind button_press_classifier_unit bpc_checker u_bpc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .press_event(press_event)
);
